### sv/mrlp_pkg.sv
// mrlp_pkg: shared types, character codes, match patterns and helpers
// for the modem response line parser; no dependencies
`default_nettype none
package mrlp_pkg;

  // result event codes
  typedef enum logic [2:0] {
    EV_SENDER  = 3'd0,
    EV_BODY    = 3'd1,
    EV_CALLER  = 3'd2,
    EV_RING    = 3'd3,
    EV_NOCARR  = 3'd4,
    EV_SIGNAL  = 3'd5,
    EV_BATTERY = 3'd6
  } event_t;

  // what the emit pass extracts
  typedef enum logic [2:0] {
    MODE_BODY,
    MODE_NUM,
    MODE_CSQ,
    MODE_CBC,
    MODE_EMPTY
  } mode_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  localparam int RUN_MAX = 63;
  localparam int CNT_W   = 6;

  // match window, entry 0 is the newest byte
  localparam int PAT_W = 10;
  typedef logic [PAT_W-1:0][7:0] win_t;

  localparam win_t PAT_CLIP = 80'("CLIP");
  localparam win_t PAT_CMT  = 80'("CMT");
  localparam win_t PAT_RING = 80'("RING");
  localparam win_t PAT_NC   = 80'("NO CARRIER");
  localparam win_t PAT_CSQ  = 80'("CSQ");
  localparam win_t PAT_CBC  = 80'("CBC");

  localparam int LEN_CLIP = 4;
  localparam int LEN_CMT  = 3;
  localparam int LEN_RING = 4;
  localparam int LEN_NC   = 10;
  localparam int LEN_CSQ  = 3;
  localparam int LEN_CBC  = 3;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic rd_issue;
    logic scan_step;
    logic decide;
    logic emit_step;
    logic flush;
    logic clear_line;
  } mrlp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_end;
    logic byte_zero;
    logic rule_none;
    logic rule_scan;
    logic step_ok;
    logic out_free;
  } mrlp_sts_t;

  function automatic logic ends_with(input win_t w, input win_t p, input int n);
    logic hit;
    hit = 1'b1;
    for (int j = 0; j < PAT_W; j++) begin
      if (j < n && w[j] != p[j]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage
`default_nettype wire

### sv/mrlp_if.sv
// mrlp_in_if / mrlp_out_if: valid-ready channels of the line parser
// depends on nothing
`default_nettype none
interface mrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrlp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] text_char;
  logic       has_char;
  logic       last_of_run;
  modport source (output valid, output event_res, output text_char, output has_char,
                  output last_of_run, input ready);
  modport sink (input valid, input event_res, input text_char, input has_char,
                input last_of_run, output ready);
endinterface
`default_nettype wire

### sv/modem_response_line_parser_unit.sv
// modem_response_line_parser_unit: top level, controller plus datapath; uses mrlp_pkg, mrlp_if
// plain byte: accepted while idle and ready stays high, so bytes can follow back to back
// line end (lf after cr): each stored char is read from the single-port store, then scanned;
//   the rule is decided, each char is read again and emitted, then flushed; out stalls hold it
// no rule: back to idle after decide; ring or no carrier: straight to flush, no emit pass
// synchronous active-low reset clears control, flags and all store valid bits
`default_nettype none
module modem_response_line_parser_unit #(
  parameter int LINE_BYTES   = 64,
  parameter int NUMBER_BYTES = 14,
  parameter int VALUE_BYTES  = 5
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mrlp_in_if.sink    in_ch,
  mrlp_out_if.source out_ch
);
  import mrlp_pkg::*;

  // command and status between sequencer and datapath
  mrlp_cmd_t cmd;
  mrlp_sts_t sts;

  // sequencer: idle/accept, match scan, decide, emit scan, flush
  mrlp_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .cmd  (cmd)
  );

  // datapath: line store, pattern flags, token tracking, result register
  mrlp_dp #(
    .LINE_BYTES  (LINE_BYTES),
    .NUMBER_BYTES(NUMBER_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .rx_byte    (in_ch.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .event_res  (out_ch.event_res),
    .text_char  (out_ch.text_char),
    .has_char   (out_ch.has_char),
    .last_of_run(out_ch.last_of_run)
  );

  // a request is taken only while the sequencer idles
  assign in_ch.ready = cmd.in_ready;
endmodule
`default_nettype wire

### sv/mrlp_ram.sv
// mrlp_ram: generic single-port ram with registered read
// depends on nothing
`default_nettype none
module mrlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/mrlp_ctrl.sv
// mrlp_ctrl: sequencer for store write, match scan, rule decision and emit scan
// depends on mrlp_pkg
`default_nettype none
module mrlp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mrlp_pkg::mrlp_sts_t sts,
  output mrlp_pkg::mrlp_cmd_t      cmd
);
  import mrlp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_S1_RD, ST_S1_EX, ST_DECIDE, ST_S2_RD, ST_S2_EX, ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.line_end) state_nxt = ST_S1_RD;
      end
      ST_S1_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_S1_EX;
      end
      ST_S1_EX: begin
        if (sts.byte_zero) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = ST_S1_RD;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.rule_none) begin
          cmd.clear_line = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (sts.rule_scan) begin
          state_nxt = ST_S2_RD;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_S2_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_S2_EX;
      end
      ST_S2_EX: begin
        if (sts.byte_zero) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.emit_step = 1'b1;
          if (sts.step_ok) state_nxt = ST_S2_RD;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

### sv/mrlp_dp.sv
// mrlp_dp: line store, valid bits, pattern flags, token extraction and result register
// depends on mrlp_pkg and mrlp_ram
`default_nettype none
module mrlp_dp #(
  parameter int LINE_BYTES   = 64,
  parameter int NUMBER_BYTES = 14,
  parameter int VALUE_BYTES  = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          rx_byte,
  input  wire mrlp_pkg::mrlp_cmd_t cmd,
  output mrlp_pkg::mrlp_sts_t      sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [2:0]               event_res,
  output logic [7:0]               text_char,
  output logic                     has_char,
  output logic                     last_of_run
);
  import mrlp_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam logic [AW-1:0]    LAST_POS = AW'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0] CAP_NUM  = CNT_W'(NUMBER_BYTES - 1);
  localparam logic [CNT_W-1:0] CAP_VAL  = CNT_W'(VALUE_BYTES - 1);
  localparam logic [CNT_W-1:0] CAP_BODY = CNT_W'(RUN_MAX);

  logic [LINE_BYTES-1:0] vld_r, vld_nxt;
  logic [AW-1:0]         wp_r, wp_nxt, ptr_r, ptr_nxt;
  logic                  prev_cr_r, prev_cr_nxt, body_exp_r, body_exp_nxt;
  logic                  ring_r, ring_nxt, rd_vld_r, rd_vld_nxt;
  logic [PAT_W-2:0][7:0] hist_r, hist_nxt;
  logic f_clip_r, f_cmt_r, f_ring_r, f_nc_r, f_csq_r, f_cbc_r;
  logic f_clip_nxt, f_cmt_nxt, f_ring_nxt, f_nc_nxt, f_csq_nxt, f_cbc_nxt;
  mode_t                 mode_r, mode_nxt, rule_mode;
  event_t                ev_r, ev_nxt, rule_ev;
  logic [CNT_W-1:0]      cap_r, cap_nxt, rule_cap, n_r, n_nxt;
  logic                  prevd_r, prevd_nxt, mprev_r, mprev_nxt;
  logic [1:0]            ck_r, ck_nxt, mk_r, mk_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [7:0]            pend_char_r, pend_char_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [2:0]            out_ev_r, out_ev_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_has_r, out_has_nxt, out_last_r, out_last_nxt;

  logic          acc, line_end_in, ram_we, byte_zero, out_free;
  logic [AW-1:0] wr_addr, ram_addr;
  logic [7:0]    ram_q, cur, delim;
  win_t          win;
  logic          rule_none, body_nxt_r, ring_nxt_r;
  logic          nd, tok_start, in_tok, cm, mprev_base, target, want, step_ok, clr;
  logic [1:0]    ck_inc, mk_base, mk_inc;

  assign acc         = in_valid && cmd.in_ready;
  assign line_end_in = acc && (rx_byte == CH_LF) && prev_cr_r;
  assign wr_addr     = (wp_r >= LAST_POS) ? '0 : wp_r;
  assign ram_we      = acc && !line_end_in;
  assign ram_addr    = ram_we ? wr_addr : ptr_r;

  mrlp_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (cmd.rd_issue),
    .addr (ram_addr),
    .wdata(rx_byte),
    .rdata(ram_q)
  );

  // never-written or cleared entries read as zero
  assign cur       = rd_vld_r ? ram_q : 8'd0;
  assign byte_zero = (cur == 8'd0);
  assign win       = {hist_r, cur};
  assign out_free  = !out_vld_r || out_ready;

  // rule priority
  always_comb begin
    rule_none  = 1'b0;
    rule_mode  = MODE_EMPTY;
    rule_ev    = EV_SENDER;
    rule_cap   = CAP_NUM;
    body_nxt_r = body_exp_r;
    ring_nxt_r = ring_r;
    if (body_exp_r) begin
      rule_mode = MODE_BODY;  rule_ev = EV_BODY;    rule_cap = CAP_BODY;
      body_nxt_r = 1'b0;
    end else if (ring_r && f_clip_r) begin
      rule_mode = MODE_NUM;   rule_ev = EV_CALLER;
      ring_nxt_r = 1'b0;
    end else if (f_cmt_r) begin
      rule_mode = MODE_NUM;   rule_ev = EV_SENDER;
      body_nxt_r = 1'b1;
    end else if (f_ring_r) begin
      rule_ev = EV_RING;
      ring_nxt_r = 1'b1;
    end else if (f_nc_r) begin
      rule_ev = EV_NOCARR;
    end else if (f_csq_r) begin
      rule_mode = MODE_CSQ;   rule_ev = EV_SIGNAL;  rule_cap = CAP_VAL;
    end else if (f_cbc_r) begin
      rule_mode = MODE_CBC;   rule_ev = EV_BATTERY; rule_cap = CAP_VAL;
    end else begin
      rule_none = 1'b1;
    end
  end

  // token tracking for the emit pass
  always_comb begin
    case (mode_r)
      MODE_NUM: delim = CH_QUOTE;
      MODE_CSQ: delim = CH_COLON;
      default:  delim = CH_COMMA;
    endcase
    nd         = (cur != delim);
    tok_start  = nd && prevd_r;
    ck_inc     = tok_start ? ((ck_r == 2'd3) ? 2'd3 : ck_r + 2'd1) : ck_r;
    in_tok     = nd && (ck_inc == 2'd2);
    cm         = (cur == CH_COMMA);
    mk_base    = tok_start ? 2'd0 : mk_r;
    mprev_base = tok_start ? 1'b1 : mprev_r;
    mk_inc     = (!cm && mprev_base) ? ((mk_base == 2'd3) ? 2'd3 : mk_base + 2'd1) : mk_base;
    case (mode_r)
      MODE_BODY: target = 1'b1;
      MODE_CSQ:  target = in_tok && !cm && (mk_inc == 2'd1) && !is_white(cur);
      MODE_NUM,
      MODE_CBC:  target = in_tok;
      default:   target = 1'b0;
    endcase
    want    = target && (n_r < cap_r);
    step_ok = !(want && pend_vld_r && !out_free);
  end

  assign clr = (cmd.flush && out_free) || cmd.clear_line;

  always_comb begin
    vld_nxt = vld_r;  wp_nxt = wp_r;  ptr_nxt = ptr_r;
    prev_cr_nxt = prev_cr_r;  body_exp_nxt = body_exp_r;  ring_nxt = ring_r;
    rd_vld_nxt = rd_vld_r;  hist_nxt = hist_r;
    f_clip_nxt = f_clip_r; f_cmt_nxt = f_cmt_r; f_ring_nxt = f_ring_r;
    f_nc_nxt = f_nc_r; f_csq_nxt = f_csq_r; f_cbc_nxt = f_cbc_r;
    mode_nxt = mode_r;  ev_nxt = ev_r;  cap_nxt = cap_r;  n_nxt = n_r;
    prevd_nxt = prevd_r;  mprev_nxt = mprev_r;  ck_nxt = ck_r;  mk_nxt = mk_r;
    pend_vld_nxt = pend_vld_r;  pend_char_nxt = pend_char_r;
    out_vld_nxt = out_ready ? 1'b0 : out_vld_r;
    out_ev_nxt = out_ev_r;  out_char_nxt = out_char_r;
    out_has_nxt = out_has_r;  out_last_nxt = out_last_r;

    if (ram_we) begin
      vld_nxt[wr_addr] = 1'b1;
      wp_nxt           = wr_addr + AW'(1);
      prev_cr_nxt      = (rx_byte == CH_CR);
    end
    if (line_end_in) begin
      prev_cr_nxt = 1'b0;
      ptr_nxt     = '0;
      hist_nxt    = '0;
      f_clip_nxt = 1'b0; f_cmt_nxt = 1'b0; f_ring_nxt = 1'b0;
      f_nc_nxt = 1'b0;   f_csq_nxt = 1'b0; f_cbc_nxt = 1'b0;
    end
    if (cmd.rd_issue) rd_vld_nxt = vld_r[ptr_r];
    if (cmd.scan_step) begin
      hist_nxt   = win[PAT_W-2:0];
      ptr_nxt    = ptr_r + AW'(1);
      f_clip_nxt = f_clip_r | ends_with(win, PAT_CLIP, LEN_CLIP);
      f_cmt_nxt  = f_cmt_r  | ends_with(win, PAT_CMT,  LEN_CMT);
      f_ring_nxt = f_ring_r | ends_with(win, PAT_RING, LEN_RING);
      f_nc_nxt   = f_nc_r   | ends_with(win, PAT_NC,   LEN_NC);
      f_csq_nxt  = f_csq_r  | ends_with(win, PAT_CSQ,  LEN_CSQ);
      f_cbc_nxt  = f_cbc_r  | ends_with(win, PAT_CBC,  LEN_CBC);
    end
    if (cmd.decide) begin
      body_exp_nxt = body_nxt_r;  ring_nxt = ring_nxt_r;
      mode_nxt = rule_mode;  ev_nxt = rule_ev;  cap_nxt = rule_cap;
      ptr_nxt = '0;  n_nxt = '0;
      prevd_nxt = 1'b1;  ck_nxt = 2'd0;  mprev_nxt = 1'b1;  mk_nxt = 2'd0;
      pend_vld_nxt = 1'b0;
    end
    if (cmd.emit_step && !byte_zero && step_ok) begin
      ptr_nxt   = ptr_r + AW'(1);
      prevd_nxt = !nd;
      ck_nxt    = ck_inc;
      mk_nxt    = mk_inc;
      mprev_nxt = cm;
      if (want) begin
        // hand the held char on, it is not the last one
        if (pend_vld_r) begin
          out_vld_nxt = 1'b1;  out_ev_nxt = ev_r;  out_char_nxt = pend_char_r;
          out_has_nxt = 1'b1;  out_last_nxt = 1'b0;
        end
        pend_vld_nxt  = 1'b1;
        pend_char_nxt = cur;
        n_nxt         = n_r + CNT_W'(1);
      end
    end
    if (cmd.flush && out_free) begin
      out_vld_nxt  = 1'b1;
      out_ev_nxt   = ev_r;
      out_char_nxt = pend_vld_r ? pend_char_r : 8'd0;
      out_has_nxt  = pend_vld_r;
      out_last_nxt = 1'b1;
    end
    if (clr) begin
      vld_nxt = '0;  wp_nxt = '0;  pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;  wp_r <= '0;  ptr_r <= '0;
      prev_cr_r <= 1'b0;  body_exp_r <= 1'b0;  ring_r <= 1'b0;  rd_vld_r <= 1'b0;
      f_clip_r <= 1'b0; f_cmt_r <= 1'b0; f_ring_r <= 1'b0;
      f_nc_r <= 1'b0;   f_csq_r <= 1'b0; f_cbc_r <= 1'b0;
      mode_r <= MODE_EMPTY;  ev_r <= EV_SENDER;  cap_r <= '0;  n_r <= '0;
      prevd_r <= 1'b1;  mprev_r <= 1'b1;  ck_r <= 2'd0;  mk_r <= 2'd0;
      pend_vld_r <= 1'b0;  out_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;  wp_r <= wp_nxt;  ptr_r <= ptr_nxt;
      prev_cr_r <= prev_cr_nxt;  body_exp_r <= body_exp_nxt;  ring_r <= ring_nxt;
      rd_vld_r <= rd_vld_nxt;
      f_clip_r <= f_clip_nxt; f_cmt_r <= f_cmt_nxt; f_ring_r <= f_ring_nxt;
      f_nc_r <= f_nc_nxt;     f_csq_r <= f_csq_nxt; f_cbc_r <= f_cbc_nxt;
      mode_r <= mode_nxt;  ev_r <= ev_nxt;  cap_r <= cap_nxt;  n_r <= n_nxt;
      prevd_r <= prevd_nxt;  mprev_r <= mprev_nxt;  ck_r <= ck_nxt;  mk_r <= mk_nxt;
      pend_vld_r <= pend_vld_nxt;  out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hist_r      <= hist_nxt;
    pend_char_r <= pend_char_nxt;
    out_ev_r    <= out_ev_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign sts.line_end  = line_end_in;
  assign sts.byte_zero = byte_zero;
  assign sts.rule_none = rule_none;
  assign sts.rule_scan = (rule_mode != MODE_EMPTY);
  assign sts.step_ok   = step_ok;
  assign sts.out_free  = out_free;

  assign out_valid   = out_vld_r;
  assign event_res   = out_ev_r;
  assign text_char   = out_char_r;
  assign has_char    = out_has_r;
  assign last_of_run = out_last_r;
endmodule
`default_nettype wire

### sv/mrlp_checker.sv
// mrlp_checker: port-level checks of the result channel, bound to the top level
// depends on mrlp_pkg
`default_nettype none
module mrlp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] event_res,
  input wire logic [7:0] text_char,
  input wire logic       has_char,
  input wire logic       last_of_run
);
  import mrlp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_char |-> text_char == 8'd0)
    else $error("empty request carries a char");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_char |-> last_of_run)
    else $error("empty run longer than one request");

  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> event_res <= 3'(EV_BATTERY))
    else $error("event code out of range");

  a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == 3'(EV_RING) || event_res == 3'(EV_NOCARR)) |-> !has_char)
    else $error("ring or no carrier with text");
endmodule

bind modem_response_line_parser_unit mrlp_checker u_mrlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_res  (out_ch.event_res),
  .text_char  (out_ch.text_char),
  .has_char   (out_ch.has_char),
  .last_of_run(out_ch.last_of_run)
);
`default_nettype wire
